[src/msfgu_pkg.sv]
// ----------------------------------------------------------------------------
// msfgu_pkg: shared types and helpers for the spin-flip Green update
// Holds the Q8.40 number types, item and status codes and the sign
// and saturation helpers used by the datapath units.
// ----------------------------------------------------------------------------
package msfgu_pkg;

  localparam int QW   = 48;   // Q8.40 signed value width
  localparam int OW   = 49;   // operand width, covers 1 - g and 1 - g unsaturated
  localparam int GW   = 47;   // gain register width
  localparam int FRAC = 40;   // fraction bits

  typedef logic signed [QW-1:0] q_t;
  typedef logic signed [OW-1:0] opnd_t;

  typedef struct packed {
    logic sat;
    q_t   val;
  } qsat_t;

  localparam q_t    ONE_Q = 48'sh0100_0000_0000;
  localparam opnd_t ONE_O = 49'sh0_0100_0000_0000;
  localparam q_t    Q_MAX = 48'sh7fff_ffff_ffff;
  localparam q_t    Q_MIN = 48'sh8000_0000_0000;

  typedef enum logic [1:0] {
    KIND_WR_ELEM = 2'd0,
    KIND_WR_SIGN = 2'd1,
    KIND_PROPOSE = 2'd2,
    KIND_RD_ELEM = 2'd3
  } kind_e;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_SAT    = 2'd1;
  localparam logic [1:0] STATUS_REJECT = 2'd2;

  localparam logic CFG_GAIN_MINUS = 1'b0;
  localparam logic CFG_GAIN_PLUS  = 1'b1;

  // Sign-extend a value to operand width.
  function automatic opnd_t ext_q(input q_t v);
    return {v[QW-1], v};
  endfunction

  // Apply a sign to a magnitude, clamping to the signed 48-bit range.
  function automatic qsat_t sign_mag(input logic neg, input logic [56:0] m);
    qsat_t       r;
    logic [56:0] lim;
    logic [56:0] mm;
    lim   = neg ? (57'd1 << 47) : ((57'd1 << 47) - 57'd1);
    r.sat = (m > lim);
    mm    = r.sat ? lim : m;
    r.val = neg ? -$signed(mm[QW-1:0]) : $signed(mm[QW-1:0]);
    return r;
  endfunction

  // Saturate a 49-bit signed sum into 48 bits.
  function automatic qsat_t sat_q48(input opnd_t x);
    qsat_t r;
    r.sat = (x[OW-1] != x[OW-2]);
    if (r.sat) begin
      r.val = x[OW-1] ? Q_MIN : Q_MAX;
    end else begin
      r.val = x[QW-1:0];
    end
    return r;
  endfunction

endpackage

[src/metropolis_spin_flip_green_update.sv]
// ----------------------------------------------------------------------------
// metropolis_spin_flip_green_update: single-flip Metropolis Green update
// Holds the up and down Green matrices of one time slice and the site
// signs, and applies accepted single-site flips as rank-one updates.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (valid/ready) carry one item: an element write, a sign
//   write, a flip proposal or an element read. Each item returns exactly
//   one output beat (valid/ready) with the read value, ratio, accept flag,
//   sign after the step and a status code.
//   The gain registers are written through a plain write port; the user
//   must do so only while the block is idle, which the block itself does
//   not enforce; both reset to 1.0. The run time of an accepted proposal
//   is set by the shared four-pass multiplier that every matrix element
//   goes through and by the 89-step divider.
//   One item is worked on at a time; ready is high only in the idle state.
//   A finished result sits in the output register, so the next item is
//   accepted while it waits; the block then stalls at its end until the
//   receiver has taken the earlier result.
//   Reset clears the signs to +1 and sets the gains; the matrices are
//   undefined until written.
// ----------------------------------------------------------------------------
module metropolis_spin_flip_green_update import msfgu_pkg::*; #(
  parameter int SITES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [GW-1:0]     cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        kind_i,
  input  logic              spin_i,
  input  logic [5:0]        row_i,
  input  logic [5:0]        col_i,
  input  logic signed [47:0] value_i,
  input  logic [5:0]        site_i,
  input  logic              sign_negative_i,
  input  logic [31:0]       uniform_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic signed [47:0] read_value_o,
  output logic signed [47:0] ratio_o,
  output logic              accepted_o,
  output logic              sign_after_o,
  output logic [1:0]        status_o
);

  localparam int SW     = $clog2(SITES);
  localparam int GAW    = 2 * SW + 1;
  localparam int GDEPTH = 2 ** GAW;
  localparam int SDEPTH = 2 ** SW;
  localparam logic [SW-1:0] LAST = SW'(SITES - 1);

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH, ST_READ,
    ST_P_GU, ST_P_GD, ST_P_WU, ST_P_WD, ST_P_WR,
    ST_U_DIV, ST_SV_COL, ST_SV_ROW, ST_U_WDIV,
    ST_U_CF, ST_U_CFW, ST_U_EL, ST_U_ELW,
    ST_FINISH
  } state_e;

  state_e          state_q, state_d;
  kind_e           kind_q, kind_d;
  logic            spin_q, spin_d, neg_q, neg_d;
  logic [5:0]      row_q, row_d, col_q, col_d, site_q, site_d;
  q_t              value_q, value_d;
  logic [31:0]     uni_q, uni_d;
  logic [GW-1:0]   gain_minus_q, gain_plus_q;
  logic [SITES-1:0] signs_q, signs_d;
  opnd_t           du_q, du_d, dd_q, dd_d;
  q_t              ru_q, ru_d, rd_q, rd_d, gdd_q, gdd_d;
  q_t              f_q, f_d, cf_q, cf_d, gold_q, gold_d;
  logic            sat_q, sat_d, mat_q, mat_d;
  logic [SW-1:0]   x_q, x_d, y_q, y_d;
  q_t              rv_q, rv_d, rat_q, rat_d;
  logic            acc_q, acc_d, sa_q, sa_d;
  logic [1:0]      st_q, st_d;
  logic            out_valid_q, out_valid_d;
  q_t              read_value_q, read_value_d, ratio_q, ratio_d;
  logic            accepted_q, accepted_d, sign_after_q, sign_after_d;
  logic [1:0]      status_q, status_d;

  // Memory and unit hookups.
  logic            g_we;
  logic [GAW-1:0]  g_waddr, g_raddr;
  q_t              g_wdata, g_rdata;
  logic            sc_we;
  logic [SW-1:0]   sc_waddr, sc_raddr;
  q_t              sc_wdata, sc_rdata;
  logic            sr_we;
  logic [SW-1:0]   sr_waddr, sr_raddr;
  opnd_t           sr_wdata, sr_rdata;
  logic            mul_start, mul_done, mul_sat;
  opnd_t           mul_a, mul_b;
  q_t              mul_res;
  logic            div_start, div_busy, div_sat;
  opnd_t           div_num;
  q_t              div_den, div_res;

  logic [SW-1:0]   row_idx, col_idx, s_idx;
  logic            elem_ok, site_ok;

  assign row_idx = SW'(row_q);
  assign col_idx = SW'(col_q);
  assign s_idx   = SW'(site_q);
  assign elem_ok = (int'(row_q) < SITES) && (int'(col_q) < SITES);
  assign site_ok = int'(site_q) < SITES;

  // Sequencer: dispatches items and steps the shared units.
  always_comb begin
    qsat_t       dr;
    logic        cur;
    logic        all_sat;
    logic [QW-1:0] uni_sh;

    cur     = signs_q[s_idx];
    all_sat = sat_q | mul_sat;
    uni_sh  = {8'd0, uni_q, 8'd0};
    dr      = '0;

    state_d = state_q;
    kind_d  = kind_q;
    spin_d  = spin_q;
    neg_d   = neg_q;
    row_d   = row_q;
    col_d   = col_q;
    site_d  = site_q;
    value_d = value_q;
    uni_d   = uni_q;
    signs_d = signs_q;
    du_d    = du_q;
    dd_d    = dd_q;
    ru_d    = ru_q;
    rd_d    = rd_q;
    gdd_d   = gdd_q;
    f_d     = f_q;
    cf_d    = cf_q;
    gold_d  = gold_q;
    sat_d   = sat_q;
    mat_d   = mat_q;
    x_d     = x_q;
    y_d     = y_q;
    rv_d    = rv_q;
    rat_d   = rat_q;
    acc_d   = acc_q;
    sa_d    = sa_q;
    st_d    = st_q;

    out_valid_d  = out_valid_q & ~out_ready_i;
    read_value_d = read_value_q;
    ratio_d      = ratio_q;
    accepted_d   = accepted_q;
    sign_after_d = sign_after_q;
    status_d     = status_q;

    g_we      = 1'b0;
    g_waddr   = {mat_q, x_q, y_q};
    g_wdata   = '0;
    g_raddr   = {mat_q, x_q, y_q};
    sc_we     = 1'b0;
    sc_waddr  = x_q;
    sc_wdata  = g_rdata;
    sc_raddr  = x_q;
    sr_we     = 1'b0;
    sr_waddr  = x_q;
    sr_wdata  = ((x_q == s_idx) ? ONE_O : opnd_t'(0)) - ext_q(g_rdata);
    sr_raddr  = y_q;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = mat_q ? dd_q : du_q;
    div_den   = mat_q ? rd_q : ru_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          kind_d  = kind_e'(kind_i);
          spin_d  = spin_i;
          row_d   = row_i;
          col_d   = col_i;
          value_d = value_i;
          site_d  = site_i;
          neg_d   = sign_negative_i;
          uni_d   = uniform_i;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        rv_d    = '0;
        rat_d   = '0;
        acc_d   = 1'b0;
        sa_d    = 1'b0;
        st_d    = STATUS_OK;
        sat_d   = 1'b0;
        state_d = ST_FINISH;
        case (kind_q)
          KIND_WR_ELEM: begin
            if (elem_ok) begin
              g_we    = 1'b1;
              g_waddr = {spin_q, row_idx, col_idx};
              g_wdata = value_q;
            end
          end
          KIND_WR_SIGN: begin
            if (site_ok) begin
              signs_d[s_idx] = neg_q;
              sa_d           = neg_q;
            end
          end
          KIND_RD_ELEM: begin
            if (elem_ok) begin
              g_raddr = {spin_q, row_idx, col_idx};
              state_d = ST_READ;
            end
          end
          KIND_PROPOSE: begin
            if (site_ok) begin
              du_d    = opnd_t'({2'b00, cur ? gain_plus_q : gain_minus_q}) - ONE_O;
              dd_d    = opnd_t'({2'b00, cur ? gain_minus_q : gain_plus_q}) - ONE_O;
              g_raddr = {1'b0, s_idx, s_idx};
              state_d = ST_P_GU;
            end
          end
          default: state_d = ST_FINISH;
        endcase
      end
      ST_READ: begin
        rv_d    = g_rdata;
        state_d = ST_FINISH;
      end
      // Up ratio product starts; the down diagonal is fetched meanwhile.
      ST_P_GU: begin
        mul_start = 1'b1;
        mul_a     = du_q;
        mul_b     = ONE_O - ext_q(g_rdata);
        g_raddr   = {1'b1, s_idx, s_idx};
        state_d   = ST_P_GD;
      end
      ST_P_GD: begin
        gdd_d   = g_rdata;
        state_d = ST_P_WU;
      end
      ST_P_WU: begin
        if (mul_done) begin
          dr        = sat_q48(ONE_O + ext_q(mul_res));
          ru_d      = dr.val;
          sat_d     = all_sat | dr.sat;
          mul_start = 1'b1;
          mul_a     = dd_q;
          mul_b     = ONE_O - ext_q(gdd_q);
          state_d   = ST_P_WD;
        end
      end
      ST_P_WD: begin
        if (mul_done) begin
          dr        = sat_q48(ONE_O + ext_q(mul_res));
          rd_d      = dr.val;
          sat_d     = all_sat | dr.sat;
          mul_start = 1'b1;
          mul_a     = ext_q(ru_q);
          mul_b     = ext_q(dr.val);
          state_d   = ST_P_WR;
        end
      end
      // Metropolis decision on the ratio product.
      ST_P_WR: begin
        if (mul_done) begin
          rat_d = mul_res;
          sat_d = all_sat;
          if (mul_res[QW-1] || mul_res == '0) begin
            st_d    = STATUS_REJECT;
            sa_d    = cur;
            state_d = ST_FINISH;
          end else if (mul_res > ONE_Q || uni_sh < $unsigned(mul_res)) begin
            mat_d   = 1'b0;
            state_d = ST_U_DIV;
          end else begin
            st_d    = all_sat ? STATUS_SAT : STATUS_OK;
            sa_d    = cur;
            state_d = ST_FINISH;
          end
        end
      end
      // Start the factor division and save the old column and row.
      ST_U_DIV: begin
        div_start = 1'b1;
        x_d       = '0;
        g_raddr   = {mat_q, SW'(0), s_idx};
        state_d   = ST_SV_COL;
      end
      ST_SV_COL: begin
        sc_we   = 1'b1;
        g_raddr = {mat_q, s_idx, x_q};
        state_d = ST_SV_ROW;
      end
      ST_SV_ROW: begin
        sr_we = 1'b1;
        if (x_q == LAST) begin
          state_d = ST_U_WDIV;
        end else begin
          x_d     = x_q + SW'(1);
          g_raddr = {mat_q, SW'(x_q + SW'(1)), s_idx};
          state_d = ST_SV_COL;
        end
      end
      ST_U_WDIV: begin
        if (!div_busy) begin
          f_d      = div_res;
          sat_d    = sat_q | div_sat;
          x_d      = '0;
          sc_raddr = '0;
          state_d  = ST_U_CF;
        end
      end
      // Column factor for row x of the update.
      ST_U_CF: begin
        mul_start = 1'b1;
        mul_a     = ext_q(sc_rdata);
        mul_b     = ext_q(f_q);
        state_d   = ST_U_CFW;
      end
      ST_U_CFW: begin
        if (mul_done) begin
          cf_d     = mul_res;
          sat_d    = all_sat;
          y_d      = '0;
          sr_raddr = '0;
          g_raddr  = {mat_q, x_q, SW'(0)};
          state_d  = ST_U_EL;
        end
      end
      // One element read-modify-write.
      ST_U_EL: begin
        mul_start = 1'b1;
        mul_a     = ext_q(cf_q);
        mul_b     = sr_rdata;
        gold_d    = g_rdata;
        state_d   = ST_U_ELW;
      end
      ST_U_ELW: begin
        if (mul_done) begin
          dr      = sat_q48(ext_q(gold_q) - ext_q(mul_res));
          g_we    = 1'b1;
          g_waddr = {mat_q, x_q, y_q};
          g_wdata = dr.val;
          sat_d   = all_sat | dr.sat;
          if (y_q != LAST) begin
            y_d      = y_q + SW'(1);
            sr_raddr = y_q + SW'(1);
            g_raddr  = {mat_q, x_q, SW'(y_q + SW'(1))};
            state_d  = ST_U_EL;
          end else if (x_q != LAST) begin
            x_d      = x_q + SW'(1);
            sc_raddr = x_q + SW'(1);
            state_d  = ST_U_CF;
          end else if (!mat_q) begin
            mat_d   = 1'b1;
            state_d = ST_U_DIV;
          end else begin
            signs_d[s_idx] = ~cur;
            sa_d           = ~cur;
            acc_d          = 1'b1;
            st_d           = (all_sat | dr.sat) ? STATUS_SAT : STATUS_OK;
            state_d        = ST_FINISH;
          end
        end
      end
      // Hand the result to the output register once it is free.
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          read_value_d = rv_q;
          ratio_d      = rat_q;
          accepted_d   = acc_q;
          sign_after_d = sa_q;
          status_d     = st_q;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State, control and gain registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      signs_q      <= '0;
      out_valid_q  <= 1'b0;
      gain_minus_q <= GW'(ONE_Q);
      gain_plus_q  <= GW'(ONE_Q);
    end else begin
      state_q     <= state_d;
      signs_q     <= signs_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_GAIN_MINUS) begin
          gain_minus_q <= cfg_data_i;
        end
        if (cfg_index_i == CFG_GAIN_PLUS) begin
          gain_plus_q <= cfg_data_i;
        end
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    spin_q       <= spin_d;
    neg_q        <= neg_d;
    row_q        <= row_d;
    col_q        <= col_d;
    site_q       <= site_d;
    value_q      <= value_d;
    uni_q        <= uni_d;
    du_q         <= du_d;
    dd_q         <= dd_d;
    ru_q         <= ru_d;
    rd_q         <= rd_d;
    gdd_q        <= gdd_d;
    f_q          <= f_d;
    cf_q         <= cf_d;
    gold_q       <= gold_d;
    sat_q        <= sat_d;
    mat_q        <= mat_d;
    x_q          <= x_d;
    y_q          <= y_d;
    rv_q         <= rv_d;
    rat_q        <= rat_d;
    acc_q        <= acc_d;
    sa_q         <= sa_d;
    st_q         <= st_d;
    read_value_q <= read_value_d;
    ratio_q      <= ratio_d;
    accepted_q   <= accepted_d;
    sign_after_q <= sign_after_d;
    status_q     <= status_d;
  end

  // Green matrices, both spins in one array.
  msfgu_ram #(.WIDTH(QW), .DEPTH(GDEPTH)) u_green (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_waddr),
    .wdata_i (g_wdata),
    .raddr_i (g_raddr),
    .rdata_o (g_rdata)
  );

  // Saved old column.
  msfgu_ram #(.WIDTH(QW), .DEPTH(SDEPTH)) u_saved_col (
    .clk_i   (clk_i),
    .we_i    (sc_we),
    .waddr_i (sc_waddr),
    .wdata_i (sc_wdata),
    .raddr_i (sc_raddr),
    .rdata_o (sc_rdata)
  );

  // Saved old row, as delta minus the row.
  msfgu_ram #(.WIDTH(OW), .DEPTH(SDEPTH)) u_saved_row (
    .clk_i   (clk_i),
    .we_i    (sr_we),
    .waddr_i (sr_waddr),
    .wdata_i (sr_wdata),
    .raddr_i (sr_raddr),
    .rdata_o (sr_rdata)
  );

  msfgu_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res),
    .sat_o   (mul_sat)
  );

  msfgu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_res),
    .sat_o   (div_sat)
  );

  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign ratio_o      = ratio_q;
  assign accepted_o   = accepted_q;
  assign sign_after_o = sign_after_q;
  assign status_o     = status_q;

endmodule

[src/msfgu_ram.sv]
// ----------------------------------------------------------------------------
// msfgu_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module msfgu_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage array with a registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/msfgu_mul.sv]
// ----------------------------------------------------------------------------
// msfgu_mul: iterative Q8.40 multiplier
// Forms a 48x48 magnitude product from four 24x24 partial products, one
// per pass, then rounds to nearest (ties away) and saturates.
// ----------------------------------------------------------------------------
module msfgu_mul import msfgu_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  opnd_t a_i,
  input  opnd_t b_i,
  output logic  done_o,
  output q_t    res_o,
  output logic  sat_o
);

  localparam int HW = QW / 2;

  logic            busy_q, busy_d;
  logic [2:0]      cnt_q, cnt_d;
  logic            neg_q, neg_d;
  logic [QW-1:0]   ua_q, ua_d, ub_q, ub_d;
  logic [QW-1:0]   pp_q, pp_d;
  logic [1:0]      sh_q, sh_d;
  logic [2*QW-1:0] acc_q, acc_d;
  logic            done_q, done_d;
  q_t              res_q, res_d;
  logic            sat_q, sat_d;

  logic [HW-1:0]   a_half, b_half;
  logic [2*QW:0]   rnd;
  qsat_t           fin;

  // Partial product selection, accumulation and final rounding.
  always_comb begin
    a_half = cnt_q[0] ? ua_q[QW-1:HW] : ua_q[HW-1:0];
    b_half = cnt_q[1] ? ub_q[QW-1:HW] : ub_q[HW-1:0];
    rnd    = {1'b0, acc_q} + ((2*QW+1)'(1) << (FRAC - 1));
    fin    = sign_mag(neg_q, rnd[2*QW:FRAC]);

    busy_d = busy_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    ua_d   = ua_q;
    ub_d   = ub_q;
    pp_d   = pp_q;
    sh_d   = sh_q;
    acc_d  = acc_q;
    done_d = 1'b0;
    res_d  = res_q;
    sat_d  = sat_q;

    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 3'd0;
      neg_d  = a_i[OW-1] ^ b_i[OW-1];
      ua_d   = a_i[OW-1] ? QW'(-a_i) : QW'(a_i);
      ub_d   = b_i[OW-1] ? QW'(-b_i) : QW'(b_i);
      acc_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 3'd1;
      if (cnt_q < 3'd4) begin
        pp_d = QW'(a_half * b_half);
        sh_d = {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};
      end
      if (cnt_q >= 3'd1 && cnt_q <= 3'd4) begin
        acc_d = acc_q + ((2*QW)'(pp_q) << (HW * int'(sh_q)));
      end
      if (cnt_q == 3'd5) begin
        res_d  = fin.val;
        sat_d  = fin.sat;
        done_d = 1'b1;
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 3'd0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    ua_q  <= ua_d;
    ub_q  <= ub_d;
    pp_q  <= pp_d;
    sh_q  <= sh_d;
    acc_q <= acc_d;
    res_q <= res_d;
    sat_q <= sat_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;
  assign sat_o  = sat_q;

endmodule

[src/msfgu_div.sv]
// ----------------------------------------------------------------------------
// msfgu_div: radix-2 restoring Q8.40 divider
// Produces one quotient bit per cycle with one guard bit, then rounds
// to nearest (ties away) and saturates. Division by zero saturates.
// ----------------------------------------------------------------------------
module msfgu_div import msfgu_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  opnd_t num_i,
  input  q_t    den_i,
  output logic  busy_o,
  output q_t    quo_o,
  output logic  sat_o
);

  localparam int DVW = QW + FRAC + 1;
  localparam int CW  = $clog2(DVW + 1);

  logic           busy_q, busy_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           neg_q, neg_d, nneg_q, nneg_d, nzero_q, nzero_d, dzero_q, dzero_d;
  logic [QW-1:0]  ud_q, ud_d;
  logic [DVW-1:0] dvd_q, dvd_d, qb_q, qb_d;
  logic [QW:0]    rem_q, rem_d;
  q_t             res_q, res_d;
  logic           sat_q, sat_d;

  logic [QW-1:0]  un;
  opnd_t          den_x;
  logic [QW:0]    rem_sh;
  logic           ge;
  logic           big;
  logic [QW+1:0]  rsum;
  qsat_t          fin;

  // Shift-subtract step and final rounding.
  always_comb begin
    den_x  = ext_q(den_i);
    un     = num_i[OW-1] ? QW'(-num_i) : QW'(num_i);
    rem_sh = {rem_q[QW-1:0], dvd_q[DVW-1]};
    ge     = (rem_sh >= {1'b0, ud_q});
    big    = (qb_q[DVW-1:FRAC+1] > QW'(128));
    rsum   = {1'b0, qb_q[QW:0]} + (QW+2)'(1);
    if (dzero_q) begin
      fin.sat = 1'b1;
      fin.val = nzero_q ? q_t'(0) : (nneg_q ? Q_MIN : Q_MAX);
    end else if (big) begin
      fin = sign_mag(neg_q, 57'd1 << 47);
    end else begin
      fin = sign_mag(neg_q, 57'(rsum[QW+1:1]));
    end

    busy_d  = busy_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    nneg_d  = nneg_q;
    nzero_d = nzero_q;
    dzero_d = dzero_q;
    ud_d    = ud_q;
    dvd_d   = dvd_q;
    qb_d    = qb_q;
    rem_d   = rem_q;
    res_d   = res_q;
    sat_d   = sat_q;

    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = '0;
      neg_d   = num_i[OW-1] ^ den_i[QW-1];
      nneg_d  = num_i[OW-1];
      nzero_d = (un == '0);
      ud_d    = den_i[QW-1] ? QW'(-den_x) : QW'(den_x);
      dzero_d = (den_i == '0);
      dvd_d   = {un, (FRAC+1)'(0)};
      qb_d    = '0;
      rem_d   = '0;
    end else if (busy_q) begin
      if (cnt_q < CW'(DVW)) begin
        rem_d = ge ? (rem_sh - {1'b0, ud_q}) : rem_sh;
        qb_d  = {qb_q[DVW-2:0], ge};
        dvd_d = {dvd_q[DVW-2:0], 1'b0};
        cnt_d = cnt_q + CW'(1);
      end else begin
        res_d  = fin.val;
        sat_d  = fin.sat;
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q   <= neg_d;
    nneg_q  <= nneg_d;
    nzero_q <= nzero_d;
    dzero_q <= dzero_d;
    ud_q    <= ud_d;
    dvd_q   <= dvd_d;
    qb_q    <= qb_d;
    rem_q   <= rem_d;
    res_q   <= res_d;
    sat_q   <= sat_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = res_q;
  assign sat_o  = sat_q;

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the spin-flip Green update
// Fills both Green matrices, then runs host writes, reads, sign writes and
// flip proposals through the valid/ready channels, under several gain
// settings and idle patterns. Every output beat is checked field by field
// against an in-bench fixed-point model of the update.
// ----------------------------------------------------------------------------
module tb;
  import msfgu_pkg::*;

  localparam int     N        = 64;
  localparam longint LIMP     = 64'sd140737488355328;  // 2^47
  localparam longint ONE_L    = 64'sd1099511627776;    // 1.0 in Q8.40
  localparam longint GAIN_MAX = LIMP - 1;
  localparam int     STALL_LIMIT = 250000;

  typedef struct {
    kind_e       kind;
    logic        spin;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [47:0] value;
    logic [5:0]  site;
    logic        neg;
    logic [31:0] uni;
  } host_beat_t;

  typedef struct {
    logic [47:0] read_value;
    logic [47:0] ratio;
    logic        accepted;
    logic        sign_after;
    logic [1:0]  status;
  } flip_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [46:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  kind_i;
  logic        spin_i;
  logic [5:0]  row_i;
  logic [5:0]  col_i;
  logic signed [47:0] value_i;
  logic [5:0]  site_i;
  logic        sign_negative_i;
  logic [31:0] uniform_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic signed [47:0] read_value_o;
  logic signed [47:0] ratio_o;
  logic        accepted_o;
  logic        sign_after_o;
  logic [1:0]  status_o;

  metropolis_spin_flip_green_update dut (.*);

  // Model state: both matrices, signs and gains.
  longint      green_up_m[N*N];
  longint      green_dn_m[N*N];
  bit          signs_m[N];
  longint      gain_minus_m;
  longint      gain_plus_m;

  host_beat_t   host_beats[$];
  flip_result_t owed_results[$];
  host_beat_t   offered;
  int          snd_idle;
  int          rcv_idle;
  int          errors;
  int          flips_left;
  bit          hold_req;
  int          quiet_cycles;

  // Clock.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Saturate to the signed 48-bit range.
  function automatic longint sat48(input longint x, inout bit sat);
    if (x > LIMP - 1) begin
      sat = 1'b1;
      return LIMP - 1;
    end
    if (x < -LIMP) begin
      sat = 1'b1;
      return -LIMP;
    end
    return x;
  endfunction

  function automatic longint signed_mag(input bit neg, input longint unsigned m,
                                        inout bit sat);
    longint unsigned lim;
    lim = neg ? LIMP : LIMP - 1;
    if (m > lim) begin
      sat = 1'b1;
      m   = lim;
    end
    return neg ? -longint'(m) : longint'(m);
  endfunction

  // Q8.40 product, rounded half away from zero.
  function automatic longint q_mul(input longint a, input longint b, inout bit sat);
    bit              neg;
    longint unsigned ua;
    longint unsigned ub;
    logic [127:0]    p;
    longint unsigned m;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    p   = {64'd0, ua} * {64'd0, ub};
    p   = p + (128'd1 << 39);
    if (p[127:104] != 0) begin
      sat = 1'b1;
      return neg ? -LIMP : LIMP - 1;
    end
    m = p[103:40];
    if (neg && m == 0) return 0;
    return signed_mag(neg, m, sat);
  endfunction

  // Q8.40 quotient, rounded half away from zero.
  function automatic longint q_div(input longint n, input longint d, inout bit sat);
    bit              neg;
    longint unsigned un;
    longint unsigned ud;
    longint unsigned q;
    longint unsigned r;
    neg = (n < 0) != (d < 0);
    un  = (n < 0) ? -n : n;
    ud  = (d < 0) ? -d : d;
    if (ud == 0) begin
      sat = 1'b1;
      if (un == 0) return 0;
      return (n < 0) ? -LIMP : LIMP - 1;
    end
    q = un / ud;
    r = un % ud;
    if (q > 128) return signed_mag(neg, LIMP, sat);
    for (int i = 0; i < 41; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= ud) begin
        r = r - ud;
        q = q | 1;
      end
    end
    q = (q + 1) >> 1;
    if (neg && q == 0) return 0;
    return signed_mag(neg, q, sat);
  endfunction

  // Determinant ratio 1 + d * (1 - g_ss).
  function automatic longint det_ratio(input longint d, input longint gss, inout bit sat);
    return sat48(ONE_L + q_mul(d, ONE_L - gss, sat), sat);
  endfunction

  // Gains of a site as deltas from 1.0 and the product of both ratios.
  function automatic longint flip_ratio(input int s, inout bit sat,
                                        output longint du, output longint dd);
    longint ru;
    longint rd;
    du = (signs_m[s] ? gain_plus_m : gain_minus_m) - ONE_L;
    dd = (signs_m[s] ? gain_minus_m : gain_plus_m) - ONE_L;
    ru = det_ratio(du, green_up_m[s*N+s], sat);
    rd = det_ratio(dd, green_dn_m[s*N+s], sat);
    return q_mul(ru, rd, sat);
  endfunction

  // Rank-one update of one matrix with the old row and column of site s.
  task automatic rank_one(inout longint g[N*N], input int s, input longint d,
                          inout bit sat);
    longint col_old[N];
    longint row_old[N];
    longint f;
    longint cf;
    for (int x = 0; x < N; x++) begin
      col_old[x] = g[x*N+s];
      row_old[x] = ((x == s) ? ONE_L : 0) - g[s*N+x];
    end
    f = q_div(d, det_ratio(d, col_old[s], sat), sat);
    for (int x = 0; x < N; x++) begin
      cf = q_mul(col_old[x], f, sat);
      for (int y = 0; y < N; y++)
        g[x*N+y] = sat48(g[x*N+y] - q_mul(cf, row_old[y], sat), sat);
    end
  endtask

  // Apply one accepted beat to the model and queue its expected result.
  task automatic green_step(input host_beat_t b);
    flip_result_t res;
    int           idx;
    bit           sat;
    longint       du;
    longint       dd;
    longint       ratio;
    res = '{default: '0};
    idx = b.row * N + b.col;
    sat = 1'b0;
    case (b.kind)
      KIND_WR_ELEM: begin
        if (b.spin) green_dn_m[idx] = longint'($signed(b.value));
        else green_up_m[idx] = longint'($signed(b.value));
      end
      KIND_WR_SIGN: begin
        signs_m[b.site] = b.neg;
        res.sign_after  = b.neg;
      end
      KIND_RD_ELEM: begin
        res.read_value = b.spin ? green_dn_m[idx][47:0] : green_up_m[idx][47:0];
      end
      default: begin
        ratio     = flip_ratio(b.site, sat, du, dd);
        res.ratio = ratio[47:0];
        if (ratio <= 0) begin
          res.status = STATUS_REJECT;
        end else begin
          if (ratio > ONE_L || longint'({b.uni, 8'd0}) < ratio) begin
            rank_one(green_up_m, b.site, du, sat);
            rank_one(green_dn_m, b.site, dd, sat);
            signs_m[b.site] = !signs_m[b.site];
            res.accepted    = 1'b1;
          end
          res.status = sat ? STATUS_SAT : STATUS_OK;
        end
        res.sign_after = signs_m[b.site];
      end
    endcase
    owed_results.push_back(res);
  endtask

  task automatic report(input string what, input logic [47:0] got, input logic [47:0] exp);
    $display("tb: mismatch %s got %h expected %h at %0t", what, got, exp, $realtime);
    errors++;
  endtask

  // Input driver: offers the oldest pending beat and holds it until taken.
  always @(posedge clk_i or negedge rst_ni) begin
    bit busy;
    if (!rst_ni) begin
      in_valid_i      <= 1'b0;
      kind_i          <= KIND_WR_ELEM;
      spin_i          <= 1'b0;
      row_i           <= '0;
      col_i           <= '0;
      value_i         <= '0;
      site_i          <= '0;
      sign_negative_i <= 1'b0;
      uniform_i       <= '0;
    end else begin
      busy = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        green_step(offered);
        void'(host_beats.pop_front());
        busy = 1'b0;
      end
      if (!busy) begin
        if (host_beats.size() > 0 && $urandom_range(99) >= snd_idle) begin
          offered         = host_beats[0];
          in_valid_i      <= 1'b1;
          kind_i          <= offered.kind;
          spin_i          <= offered.spin;
          row_i           <= offered.row;
          col_i           <= offered.col;
          value_i         <= offered.value;
          site_i          <= offered.site;
          sign_negative_i <= offered.neg;
          uniform_i       <= offered.uni;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each beat and drives ready, with one long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    flip_result_t exp;
    int           hold_left;
    bit           hold_done;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (owed_results.size() == 0) begin
          report("unexpected beat", ratio_o, '0);
        end else begin
          exp = owed_results.pop_front();
          if (read_value_o !== exp.read_value) report("read_value", read_value_o, exp.read_value);
          if (ratio_o !== exp.ratio) report("ratio", ratio_o, exp.ratio);
          if (accepted_o !== exp.accepted) report("accepted", accepted_o, exp.accepted);
          if (sign_after_o !== exp.sign_after) report("sign_after", sign_after_o, exp.sign_after);
          if (status_o !== exp.status) report("status", status_o, exp.status);
        end
      end
      if (hold_req && !hold_done) begin
        hold_left = 3000;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  // Watchdog on cycles without any beat.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic drain();
    while (host_beats.size() != 0 || owed_results.size() != 0 || in_valid_i)
      @(posedge clk_i);
  endtask

  task automatic write_gain(input logic idx, input longint g);
    drain();
    repeat (8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= g[46:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_GAIN_MINUS) gain_minus_m = g;
    else gain_plus_m = g;
  endtask

  function automatic host_beat_t blank_beat(input kind_e k);
    host_beat_t b;
    b.kind  = k;
    b.spin  = $urandom_range(1);
    b.row   = $urandom_range(63);
    b.col   = $urandom_range(63);
    b.value = {$urandom, $urandom};
    b.site  = $urandom_range(63);
    b.neg   = $urandom_range(1);
    b.uni   = $urandom;
    return b;
  endfunction

  // Small element value, mostly near zero, larger on the diagonal.
  function automatic logic [47:0] tame_value(input bit diag);
    longint v;
    v = longint'($urandom_range(32'h3fff_ffff)) << 8;   // up to about 0.25
    v = v - (longint'(1) << 37);
    if (diag) v = v + (ONE_L >>> 1);
    return v[47:0];
  endfunction

  task automatic push_elem(input bit spin, input int r, input int c, input logic [47:0] v);
    host_beat_t b;
    b       = blank_beat(KIND_WR_ELEM);
    b.spin  = spin;
    b.row   = r;
    b.col   = c;
    b.value = v;
    host_beats.push_back(b);
  endtask

  task automatic push_read(input bit spin, input int r, input int c);
    host_beat_t b;
    b      = blank_beat(KIND_RD_ELEM);
    b.spin = spin;
    b.row  = r;
    b.col  = c;
    host_beats.push_back(b);
  endtask

  task automatic push_sign(input int s, input bit neg);
    host_beat_t b;
    b      = blank_beat(KIND_WR_SIGN);
    b.site = s;
    b.neg  = neg;
    host_beats.push_back(b);
  endtask

  // A proposal whose outcome is steered so that full updates stay few.
  task automatic push_flip(input int s, input bit want_accept);
    host_beat_t b;
    bit         sat;
    longint     du;
    longint     dd;
    longint     ratio;
    bit         can_reject;
    drain();
    sat        = 1'b0;
    ratio      = flip_ratio(s, sat, du, dd);
    can_reject = (ratio <= 0) || (ratio <= longint'(32'hffff_ffff) * 256);
    b          = blank_beat(KIND_PROPOSE);
    b.site     = s;
    if (ratio > 0 && flips_left > 0 && (want_accept || !can_reject)) begin
      if (ratio <= ONE_L) b.uni = $urandom_range(32'((ratio - 1) / 256));
      flips_left--;
    end else if (can_reject) begin
      if (ratio > 0) b.uni = $urandom_range(32'hffff_ffff, 32'((ratio + 255) / 256));
    end else begin
      b = blank_beat(KIND_RD_ELEM);
    end
    host_beats.push_back(b);
  endtask

  task automatic random_items(input int count);
    int pick;
    host_beat_t b;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        b = blank_beat(KIND_WR_ELEM);
        if ($urandom_range(3) != 0) b.value = tame_value(b.row == b.col);
        host_beats.push_back(b);
      end else if (pick < 50) begin
        host_beats.push_back(blank_beat(KIND_WR_SIGN));
      end else if (pick < 70) begin
        host_beats.push_back(blank_beat(KIND_RD_ELEM));
      end else begin
        push_flip($urandom_range(63), $urandom_range(9) == 0);
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = CFG_GAIN_MINUS;
    cfg_data_i   = '0;
    errors       = 0;
    quiet_cycles = 0;
    hold_req     = 1'b0;
    flips_left   = 8;
    gain_minus_m = ONE_L;
    gain_plus_m  = ONE_L;
    foreach (signs_m[i]) signs_m[i] = 1'b0;
    snd_idle = 28;
    rcv_idle = 69;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Fill both matrices so no proposal ever reads an unwritten element.
    for (int sp = 0; sp < 2; sp++)
      for (int r = 0; r < N; r++)
        for (int c = 0; c < N; c++)
          push_elem(sp, r, c, tame_value(r == c));

    // Directed: extreme values and corners, sign writes, proposals.
    push_elem(0, 0, 63, 48'h7fff_ffff_ffff);
    push_elem(1, 63, 0, 48'h8000_0000_0000);
    push_elem(0, 63, 63, 48'h0);
    push_read(0, 0, 63);
    push_read(1, 63, 0);
    push_read(0, 63, 63);
    push_sign(0, 1'b1);
    push_sign(63, 1'b1);
    push_sign(0, 1'b0);
    push_flip(5, 1'b1);
    push_read(1, 5, 5);
    push_sign(10, 1'b1);
    push_flip(10, 1'b0);
    write_gain(CFG_GAIN_MINUS, 0);
    write_gain(CFG_GAIN_PLUS, GAIN_MAX);
    // Zero gain leaves the up ratio equal to the diagonal: nonpositive is rejected.
    push_elem(0, 20, 20, 48'h8000_0000_0000);
    push_elem(1, 20, 20, 48'h0);
    push_flip(20, 1'b0);
    push_elem(0, 21, 21, 48'h0);
    push_flip(21, 1'b0);
    push_elem(0, 22, 22, tame_value(1'b1));
    push_flip(22, 1'b0);
    random_items(40);

    // Swapped idling, moderate gains, and one long receiver hold-off.
    drain();
    snd_idle = 69;
    rcv_idle = 28;
    write_gain(CFG_GAIN_MINUS, longint'($urandom_range(1 << 22, 1 << 18)) << 20);
    write_gain(CFG_GAIN_PLUS, longint'($urandom_range(1 << 22, 1 << 18)) << 20);
    hold_req = 1'b1;
    for (int i = 0; i < 6; i++) host_beats.push_back(blank_beat(KIND_RD_ELEM));
    random_items(45);

    // No idling, gains at the opposite extremes.
    drain();
    snd_idle = 0;
    rcv_idle = 0;
    write_gain(CFG_GAIN_MINUS, GAIN_MAX);
    write_gain(CFG_GAIN_PLUS, 0);
    random_items(45);

    drain();
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
src/msfgu_pkg.sv
src/msfgu_ram.sv
src/msfgu_mul.sv
src/msfgu_div.sv
src/metropolis_spin_flip_green_update.sv
test/tb.sv
